[design/spgh_pkg.sv]
// Shared widths, register indexes and types for the spectrum peak gravity hold unit.
package spgh_pkg;

    localparam int BIN_W      = 10;
    localparam int NUM_BINS   = 1 << BIN_W;
    localparam int LEVEL_W    = 16;
    localparam int TIME_W     = 16;
    localparam int RATE_W     = 16;
    localparam int FRAC_W     = 8;
    localparam int PROD_W     = RATE_W + TIME_W;
    localparam int DROP_W     = PROD_W - FRAC_W;
    localparam int FALL_W     = DROP_W + 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_GRAVITY_RATE = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_TIME_STEP    = CFG_IDX_W'(1);

    localparam logic [RATE_W-1:0] GRAVITY_RATE_RESET = RATE_W'(256);
    localparam logic [TIME_W-1:0] TIME_STEP_RESET    = TIME_W'(256);

    typedef logic signed [LEVEL_W-1:0] t_level;
    typedef logic [TIME_W-1:0]         t_time;
    typedef logic [BIN_W-1:0]          t_bin;

    typedef struct packed {
        t_level held;
        t_time  elapsed;
    } t_entry;

    localparam t_level LEVEL_MIN = {1'b1, {(LEVEL_W-1){1'b0}}};
    localparam t_time  TIME_MAX  = {TIME_W{1'b1}};

endpackage

[design/spgh_if.sv]
// Handshake channel interfaces: bin input, level output and configuration writes.
interface spgh_in_if
    import spgh_pkg::*;
;
    logic                      valid;
    logic                      ready;
    logic [BIN_W-1:0]          bin_index;
    logic signed [LEVEL_W-1:0] magnitude;

    modport source (output valid, output bin_index, output magnitude, input ready);
    modport sink   (input valid, input bin_index, input magnitude, output ready);
endinterface

interface spgh_out_if
    import spgh_pkg::*;
;
    logic                      valid;
    logic                      ready;
    logic signed [LEVEL_W-1:0] shown_level;
    logic                      falling;

    modport source (output valid, output shown_level, output falling, input ready);
    modport sink   (input valid, input shown_level, input falling, output ready);
endinterface

interface spgh_cfg_if
    import spgh_pkg::*;
;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

[design/spectrum_peak_gravity_hold_unit.sv]
// Spectrum peak hold with gravity fall-off: per-bin held level and elapsed time in one RAM.
// Pipeline: RAM read, multiply, update/output reg.
// Throughput: 1 beat per cycle for distinct bins while the output is not stalled; a bin
// matching an item in s1 or s2 waits for its write-back, which an output stall delays.
// Reset: synchronous, active low; a clearing pass then zeroes all NUM_BINS entries
// with input ready low; configuration writes are taken throughout.
module spectrum_peak_gravity_hold_unit
    import spgh_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    spgh_cfg_if.sink   i_cfg,
    spgh_in_if.sink    i_in,
    spgh_out_if.source o_out
);

    // ------------------------------------------------------------------
    // Configuration registers. Writes are always taken; unknown indexes
    // fall through the default arm and change nothing.
    // ------------------------------------------------------------------
    logic [RATE_W-1:0] r_gravity_rate;
    logic [TIME_W-1:0] r_time_step;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gravity_rate <= GRAVITY_RATE_RESET;
            r_time_step    <= TIME_STEP_RESET;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                REG_GRAVITY_RATE: r_gravity_rate <= RATE_W'(i_cfg.data);
                REG_TIME_STEP:    r_time_step    <= TIME_W'(i_cfg.data);
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Clearing pass after reset: walks every entry once, writing zero.
    // ------------------------------------------------------------------
    logic r_clr_busy;
    t_bin r_clr_addr;
    t_bin n_clr_addr;

    assign n_clr_addr = r_clr_addr + 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clr_busy) begin
            r_clr_addr <= n_clr_addr;
            if (r_clr_addr == BIN_W'(NUM_BINS - 1)) begin
                r_clr_busy <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Pipeline control.
    //   s1: RAM read data returns, multiply gravity * elapsed
    //   s2: subtract, saturate, compare, write back, load output reg
    // Each stage moves when the stage after it is empty or moving, so a
    // finished beat waiting in the output reg does not stop new input
    // until the bubbles are used up.
    // ------------------------------------------------------------------
    logic   r_s1_valid;
    t_bin   r_s1_bin;
    t_level r_s1_mag;

    logic              r_s2_valid;
    t_bin              r_s2_bin;
    t_level            r_s2_mag;
    t_level            r_s2_held;
    t_time             r_s2_elapsed;
    logic [PROD_W-1:0] r_s2_prod;

    logic   r_out_valid;
    t_level r_out_level;
    logic   r_out_falling;

    logic en2, en1, en0;
    logic in_hazard;
    logic in_acc;
    t_bin in_bin;

    assign en2 = !r_out_valid || o_out.ready;
    assign en1 = !r_s2_valid || en2;
    assign en0 = !r_s1_valid || en1;

    // bin index is already reduced to the table size by its width
    assign in_bin = i_in.bin_index;

    // Read-modify-write interlock: an entry still owned by s1 or s2 has
    // not been written back yet, so the same bin waits.
    assign in_hazard = (r_s1_valid && (r_s1_bin == in_bin)) ||
                       (r_s2_valid && (r_s2_bin == in_bin));

    assign i_in.ready = en0 && !r_clr_busy && !in_hazard;
    assign in_acc     = i_in.valid && i_in.ready;

    // ------------------------------------------------------------------
    // State RAM: one write port (clear or write-back), one registered read.
    // ------------------------------------------------------------------
    t_entry r_mem [NUM_BINS];
    t_entry r_rd_data;
    logic   mem_we;
    t_bin   mem_waddr;
    t_entry mem_wdata;
    t_entry upd_entry;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        if (in_acc) begin
            r_rd_data <= r_mem[in_bin];
        end
    end

    // pipeline is empty during the clearing pass, so the mux never collides
    assign mem_we    = r_clr_busy || (r_s2_valid && en2);
    assign mem_waddr = r_clr_busy ? r_clr_addr : r_s2_bin;
    assign mem_wdata = r_clr_busy ? t_entry'('0) : upd_entry;

    // ------------------------------------------------------------------
    // s1 -> s2: product of rate and elapsed time, registered.
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
        end else begin
            if (en0) begin
                r_s1_valid <= in_acc;
            end
            if (en1) begin
                r_s2_valid <= r_s1_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_bin <= in_bin;
            r_s1_mag <= i_in.magnitude;
        end
        if (r_s1_valid && en1) begin
            r_s2_bin     <= r_s1_bin;
            r_s2_mag     <= r_s1_mag;
            r_s2_held    <= r_rd_data.held;
            r_s2_elapsed <= r_rd_data.elapsed;
            r_s2_prod    <= PROD_W'(r_gravity_rate) * PROD_W'(r_rd_data.elapsed);
        end
    end

    // ------------------------------------------------------------------
    // s2: fallen = held - (product >> 8), floored at the signed minimum.
    // The fallen peak survives only when strictly above the new magnitude;
    // a tie takes the new magnitude and restarts the timer.
    // ------------------------------------------------------------------
    logic [DROP_W-1:0]        drop;
    logic signed [FALL_W-1:0] fallen_full;
    t_level                   fallen_sat;
    logic                     keep_peak;
    logic [TIME_W:0]          time_sum;
    t_time                    time_sat;

    always_comb begin
        drop        = r_s2_prod[PROD_W-1:FRAC_W];
        fallen_full = FALL_W'(r_s2_held) - signed'(FALL_W'(drop));
        if (fallen_full < FALL_W'(LEVEL_MIN)) begin
            fallen_sat = LEVEL_MIN;
        end else begin
            fallen_sat = fallen_full[LEVEL_W-1:0];
        end
        keep_peak = fallen_sat > r_s2_mag;
        time_sum  = {1'b0, r_s2_elapsed} + {1'b0, r_time_step};
        time_sat  = time_sum[TIME_W] ? TIME_MAX : time_sum[TIME_W-1:0];
        if (keep_peak) begin
            upd_entry.held    = fallen_sat;
            upd_entry.elapsed = time_sat;
        end else begin
            upd_entry.held    = r_s2_mag;
            upd_entry.elapsed = '0;
        end
    end

    // ------------------------------------------------------------------
    // Output register.
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en2) begin
            r_out_valid <= r_s2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_s2_valid && en2) begin
            r_out_level   <= upd_entry.held;
            r_out_falling <= keep_peak;
        end
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.shown_level = r_out_level;
    assign o_out.falling     = r_out_falling;

endmodule

[design/spgh_checker.sv]
// Port-level checks for the spectrum peak gravity hold unit, bound to the top level.
module spgh_checker
    import spgh_pkg::*;
(
    input logic         i_clk,
    input logic         i_rst_n,
    input logic         i_in_ready,
    input logic         i_out_valid,
    input logic         i_out_ready,
    input logic [LEVEL_W-1:0] i_out_level,
    input logic         i_out_falling
);

    // reset leaves nothing to deliver and the clearing pass holds off input
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_in_ready && !i_out_valid)
        else $error("input ready or output valid right after reset");

    // a falling level beat a magnitude, so it can never sit at the floor
    a_fall_floor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_falling |-> i_out_level != LEVEL_MIN)
        else $error("falling beat shows the saturated floor");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("output beat dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> $stable(i_out_level) && $stable(i_out_falling))
        else $error("output payload changed while stalled");

endmodule

bind spectrum_peak_gravity_hold_unit spgh_checker u_spgh_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_ready    (i_in.ready),
    .i_out_valid   (o_out.valid),
    .i_out_ready   (o_out.ready),
    .i_out_level   (o_out.shown_level),
    .i_out_falling (o_out.falling)
);
